// ----- design/prl_pkg.sv -----
package prl_pkg;

   // Default list depth.
   localparam int CAPACITY = 64;

   // Field widths of the request and response words.
   localparam int OP_W     = 2;
   localparam int POS_W    = 7;
   localparam int ID_W     = 32;
   localparam int NAME_W   = 64;
   localparam int SCORE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // One stored record.
   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic [NAME_W-1:0]      name;
      logic [SCORE_W-1:0]     score;
   } prl_record_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                req_load;
      logic                walk_set_count;
      logic                walk_set_pos;
      logic                walk_clear;
      logic                walk_inc;
      logic                walk_dec;
      logic                addr_below;
      logic                mem_rd;
      logic                mem_wr;
      logic                wr_new;
      logic                count_inc;
      logic                count_dec;
      logic                hold_load_new;
      logic                hold_load_rd;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_zero;
      logic                emit_last;
   } prl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            ins_pos_bad;
      logic            acc_pos_bad;
      logic            walk_at_ins;
      logic            walk_at_count;
      logic            name_match;
      logic            out_free;
   } prl_stat_type;

endpackage

// ----- design/prl_if.sv -----
// Request channel: one word per list operation.
interface prl_req_if;
   logic                                valid;
   logic                                ready;
   logic [prl_pkg::OP_W-1:0]            op;
   logic [prl_pkg::POS_W-1:0]           position;
   logic signed [prl_pkg::ID_W-1:0]     student_id;
   logic [prl_pkg::NAME_W-1:0]          name_key;
   logic [prl_pkg::SCORE_W-1:0]         score_bits;

   modport source (output valid, op, position, student_id, name_key, score_bits,
                   input ready);
   modport sink (input valid, op, position, student_id, name_key, score_bits,
                 output ready);
endinterface

// Response channel: one or more words per operation, the final one marked.
interface prl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [prl_pkg::STATUS_W-1:0]        status;
   logic [prl_pkg::POS_W-1:0]           found_position;
   logic signed [prl_pkg::ID_W-1:0]     record_id;
   logic [prl_pkg::NAME_W-1:0]          record_name;
   logic [prl_pkg::SCORE_W-1:0]         record_score;
   logic [prl_pkg::CNT_W-1:0]           entry_total;
   logic                                last;

   modport source (output valid, status, found_position, record_id, record_name,
                   record_score, entry_total, last,
                   input ready);
   modport sink (input valid, status, found_position, record_id, record_name,
                 record_score, entry_total, last,
                 output ready);
endinterface

// ----- design/positional_record_list_core.sv -----
// One operation at a time: the next word is taken once the last response word is loaded.
// The single-port record store sets the rate: every moved or searched entry costs a store
// read and, for shifts, a store write. Synchronous active-high reset empties the list and
// clears control state; store contents are not cleared and are never read before being written.
module positional_record_list_core #(
   parameter int CAPACITY = prl_pkg::CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   prl_req_if.sink req_bus,
   prl_rsp_if.source rsp_bus
);

   prl_pkg::prl_cmd_type    cmd;
   prl_pkg::prl_stat_type   stat;
   logic                    ctl_ready;

   assign req_bus.ready = ctl_ready;

   prl_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   prl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_bus.op),
      .req_position       (req_bus.position),
      .req_student_id     (req_bus.student_id),
      .req_name_key       (req_bus.name_key),
      .req_score_bits     (req_bus.score_bits),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_status         (rsp_bus.status),
      .rsp_found_position (rsp_bus.found_position),
      .rsp_record_id      (rsp_bus.record_id),
      .rsp_record_name    (rsp_bus.record_name),
      .rsp_record_score   (rsp_bus.record_score),
      .rsp_entry_total    (rsp_bus.entry_total),
      .rsp_last           (rsp_bus.last)
   );

endmodule

// ----- design/prl_datapath.sv -----
module prl_datapath #(
   parameter int CAPACITY = prl_pkg::CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  prl_pkg::prl_cmd_type              cmd,
   output prl_pkg::prl_stat_type             stat,
   input  logic [prl_pkg::OP_W-1:0]          req_op,
   input  logic [prl_pkg::POS_W-1:0]         req_position,
   input  logic signed [prl_pkg::ID_W-1:0]   req_student_id,
   input  logic [prl_pkg::NAME_W-1:0]        req_name_key,
   input  logic [prl_pkg::SCORE_W-1:0]       req_score_bits,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [prl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [prl_pkg::POS_W-1:0]         rsp_found_position,
   output logic signed [prl_pkg::ID_W-1:0]   rsp_record_id,
   output logic [prl_pkg::NAME_W-1:0]        rsp_record_name,
   output logic [prl_pkg::SCORE_W-1:0]       rsp_record_score,
   output logic [prl_pkg::CNT_W-1:0]         rsp_entry_total,
   output logic                              rsp_last
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   prl_pkg::prl_record_type          record_store_ff [CAPACITY];
   prl_pkg::prl_record_type          rd_data_ff;

   logic [prl_pkg::OP_W-1:0]         op_ff;
   logic [prl_pkg::POS_W-1:0]        pos_ff;
   prl_pkg::prl_record_type          req_rec_ff;

   logic [prl_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [prl_pkg::CNT_W-1:0]        walk_ff, walk_in;
   logic [prl_pkg::CNT_W-1:0]        addr_full;
   logic [IDX_W-1:0]                 addr;
   prl_pkg::prl_record_type          wr_rec;

   logic [prl_pkg::POS_W-1:0]        hold_pos_ff, hold_pos_in;
   prl_pkg::prl_record_type          hold_rec_ff, hold_rec_in;

   logic                             out_valid_ff, out_valid_in;
   logic [prl_pkg::STATUS_W-1:0]     out_status_ff;
   logic [prl_pkg::POS_W-1:0]        out_pos_ff;
   prl_pkg::prl_record_type          out_rec_ff;
   logic [prl_pkg::CNT_W-1:0]        out_total_ff;
   logic                             out_last_ff;

   // Latch the request word when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff            <= req_op;
         pos_ff           <= req_position;
         req_rec_ff.id    <= req_student_id;
         req_rec_ff.name  <= req_name_key;
         req_rec_ff.score <= req_score_bits;
      end
   end

   // Walk index steps through the store during shifts and searches.
   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_set_count) begin
         walk_in = count_ff;
      end else if (cmd.walk_set_pos) begin
         walk_in = pos_ff - 7'd1;
      end else if (cmd.walk_clear) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = walk_ff + 7'd1;
      end else if (cmd.walk_dec) begin
         walk_in = walk_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 7'd1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Single-port record store; the read word is registered.
   assign addr_full = cmd.addr_below ? (walk_ff - 7'd1) : walk_ff;
   assign addr      = addr_full[IDX_W-1:0];
   assign wr_rec    = cmd.wr_new ? req_rec_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         record_store_ff[addr] <= wr_rec;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= record_store_ff[addr];
      end
   end

   // Hold register keeps the record that the next response word reports.
   always_comb begin
      hold_pos_in = hold_pos_ff;
      hold_rec_in = hold_rec_ff;
      if (cmd.hold_load_new) begin
         hold_pos_in = pos_ff;
         hold_rec_in = req_rec_ff;
      end else if (cmd.hold_load_rd) begin
         hold_pos_in = walk_ff + 7'd1;
         hold_rec_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      hold_pos_ff <= hold_pos_in;
      hold_rec_ff <= hold_rec_in;
   end

   // Output register; it frees up in the cycle its word is taken.
   assign out_valid_in = cmd.emit | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= cmd.emit_status;
         out_pos_ff    <= cmd.emit_zero ? '0 : hold_pos_ff;
         out_rec_ff    <= cmd.emit_zero ? '0 : hold_rec_ff;
         out_total_ff  <= count_in;
         out_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_found_position = out_pos_ff;
   assign rsp_record_id      = out_rec_ff.id;
   assign rsp_record_name    = out_rec_ff.name;
   assign rsp_record_score   = out_rec_ff.score;
   assign rsp_entry_total    = out_total_ff;
   assign rsp_last           = out_last_ff;

   // Checks reported to the controller.
   always_comb begin
      stat.op            = op_ff;
      stat.full          = (count_ff >= prl_pkg::CNT_W'(CAPACITY));
      stat.empty         = (count_ff == '0);
      stat.ins_pos_bad   = (pos_ff == '0) ||
                           ({1'b0, pos_ff} > ({1'b0, count_ff} + 8'd1));
      stat.acc_pos_bad   = (pos_ff == '0) || (pos_ff > count_ff);
      stat.walk_at_ins   = (({1'b0, walk_ff} + 8'd1) == {1'b0, pos_ff});
      stat.walk_at_count = (walk_ff == count_ff);
      stat.name_match    = (rd_data_ff.name == req_rec_ff.name);
      stat.out_free      = ~out_valid_ff | rsp_ready;
   end

endmodule

// ----- design/prl_controller.sv -----
module prl_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  prl_pkg::prl_stat_type  stat,
   output prl_pkg::prl_cmd_type   cmd
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DECIDE   = 13'b0000000000010,
      S_INS_CHK  = 13'b0000000000100,
      S_INS_WR   = 13'b0000000001000,
      S_GET      = 13'b0000000010000,
      S_HOLD     = 13'b0000000100000,
      S_DEL_CHK  = 13'b0000001000000,
      S_DEL_WR   = 13'b0000010000000,
      S_FIND_CHK = 13'b0000100000000,
      S_FIND_CMP = 13'b0001000000000,
      S_FIND_END = 13'b0010000000000,
      S_REPLY    = 13'b0100000000000,
      S_REJECT   = 13'b1000000000000
   } prl_state_type;

   prl_state_type                  state_ff, state_in;
   logic [prl_pkg::STATUS_W-1:0]   rej_status_ff, rej_status_in;
   logic                           pend_ff, pend_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      rej_status_in = rej_status_ff;
      pend_in       = pend_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (stat.op)
               prl_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     rej_status_in = prl_pkg::ST_FULL;
                     state_in      = S_REJECT;
                  end else if (stat.ins_pos_bad) begin
                     rej_status_in = prl_pkg::ST_BADPOS;
                     state_in      = S_REJECT;
                  end else begin
                     cmd.walk_set_count = 1'b1;
                     state_in           = S_INS_CHK;
                  end
               end
               prl_pkg::OP_DELETE, prl_pkg::OP_READ: begin
                  if (stat.empty) begin
                     rej_status_in = prl_pkg::ST_EMPTY;
                     state_in      = S_REJECT;
                  end else if (stat.acc_pos_bad) begin
                     rej_status_in = prl_pkg::ST_BADPOS;
                     state_in      = S_REJECT;
                  end else begin
                     cmd.walk_set_pos = 1'b1;
                     state_in         = S_GET;
                  end
               end
               default: begin
                  cmd.walk_clear = 1'b1;
                  pend_in        = 1'b0;
                  state_in       = S_FIND_CHK;
               end
            endcase
         end
         // Insert: move entries up one at a time from the top down.
         S_INS_CHK: begin
            if (stat.walk_at_ins) begin
               cmd.mem_wr        = 1'b1;
               cmd.wr_new        = 1'b1;
               cmd.count_inc     = 1'b1;
               cmd.hold_load_new = 1'b1;
               state_in          = S_REPLY;
            end else begin
               cmd.mem_rd     = 1'b1;
               cmd.addr_below = 1'b1;
               state_in       = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.walk_dec = 1'b1;
            state_in     = S_INS_CHK;
         end
         // Delete and read fetch the addressed record first.
         S_GET: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_HOLD;
         end
         S_HOLD: begin
            cmd.hold_load_rd = 1'b1;
            if (stat.op == prl_pkg::OP_DELETE) begin
               cmd.walk_inc = 1'b1;
               state_in     = S_DEL_CHK;
            end else begin
               state_in = S_REPLY;
            end
         end
         // Delete: move later entries down one at a time.
         S_DEL_CHK: begin
            if (stat.walk_at_count) begin
               cmd.count_dec = 1'b1;
               state_in      = S_REPLY;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.mem_wr     = 1'b1;
            cmd.addr_below = 1'b1;
            cmd.walk_inc   = 1'b1;
            state_in       = S_DEL_CHK;
         end
         // Find: one match is kept back so the final one can be marked.
         S_FIND_CHK: begin
            if (stat.walk_at_count) begin
               state_in = S_FIND_END;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (!stat.name_match) begin
               cmd.walk_inc = 1'b1;
               state_in     = S_FIND_CHK;
            end else if (!pend_ff) begin
               cmd.hold_load_rd = 1'b1;
               cmd.walk_inc     = 1'b1;
               pend_in          = 1'b1;
               state_in         = S_FIND_CHK;
            end else if (stat.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_status  = prl_pkg::ST_OK;
               cmd.hold_load_rd = 1'b1;
               cmd.walk_inc     = 1'b1;
               state_in         = S_FIND_CHK;
            end
         end
         S_FIND_END: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (pend_ff) begin
                  cmd.emit_status = prl_pkg::ST_OK;
               end else begin
                  cmd.emit_status = prl_pkg::ST_NOTFOUND;
                  cmd.emit_zero   = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = prl_pkg::ST_OK;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_REJECT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = rej_status_ff;
               cmd.emit_zero   = 1'b1;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rej_status_ff <= rej_status_in;
   end

endmodule
